>>> design/gpc_pkg.sv
package gpc_pkg;

  localparam int POSITION_BITS_DEF  = 16;
  localparam int COS_INDEX_BITS_DEF = 10;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRADIENT_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS_BASE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS_AMPLITUDE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_RED      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_GREEN    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_BLUE     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLY_COEFFS   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MAP   = 3'd7;

  localparam logic        MODE_COSINE = 1'b0;
  localparam logic [7:0]  COS_BASE_RST      = 8'd128;
  localparam logic [7:0]  COS_AMPLITUDE_RST = 8'd100;
  localparam logic [3:0]  FREQ_RED_RST      = 4'd1;
  localparam logic [3:0]  FREQ_GREEN_RST    = 4'd2;
  localparam logic [3:0]  FREQ_BLUE_RST     = 4'd3;
  localparam logic [47:0] POLY_COEFFS_RST   = 48'h0880_0F00_0900;
  localparam logic [5:0]  CHANNEL_MAP_RST   = 6'd36;

  localparam logic [1:0] MAP_RED   = 2'd0;
  localparam logic [1:0] MAP_GREEN = 2'd1;
  localparam logic [1:0] MAP_BLUE  = 2'd2;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // register stages: cosine lane 4, delay 2, output 1
  localparam int COS_LATENCY  = 4;
  localparam int POLY_LATENCY = 6;
  localparam int LATENCY      = POLY_LATENCY + 1;

endpackage

>>> design/gpc_cos_lane.sv
module gpc_cos_lane #(
  parameter int POSITION_BITS  = gpc_pkg::POSITION_BITS_DEF,
  parameter int COS_INDEX_BITS = gpc_pkg::COS_INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic [3:0]               freq,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [7:0]               base,
  input  logic [7:0]               amp,
  output logic [7:0]               chan
);

  localparam int N    = 1 << COS_INDEX_BITS;
  localparam int NEED = COS_INDEX_BITS + 2;

  typedef logic [15:0] rom_t [0:N];

  // shift-subtract quotient, elaboration only
  function automatic longint unsigned div_u64(longint unsigned a, longint unsigned b);
    longint unsigned qt;
    longint unsigned rm;
    qt = 64'd0;
    rm = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      rm = {rm[62:0], a[k]};
      if (rm >= b) begin
        rm    = rm - b;
        qt[k] = 1'b1;
      end
    end
    return qt;
  endfunction

  function automatic rom_t cos_rom_build();
    rom_t            r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    for (int i = 0; i <= N; i++) begin
      x    = (gpc_pkg::PI_Q30 * longint'(i)) >> (COS_INDEX_BITS + 1);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = 64'sd1 << 30;
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >> 30;
        term = div_u64(term, 64'((2 * n - 1) * (2 * n)));
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      r[i] = v[15:0];
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = cos_rom_build();

  logic [POSITION_BITS+3:0]  ph_full;
  logic [POSITION_BITS-1:0]  ph;
  logic [NEED-1:0]           p;
  logic [1:0]                q;
  logic [COS_INDEX_BITS-1:0] idx;
  logic [COS_INDEX_BITS:0]   addr_nxt;

  logic [COS_INDEX_BITS:0]   addr_r;
  logic                      neg1_r;
  logic [15:0]               mag_r;
  logic                      neg2_r;
  logic [23:0]               prod_r;
  logic                      neg3_r;
  logic [7:0]                chan_r;

  logic signed [25:0]        v;
  logic [7:0]                chan_nxt;

  assign ph_full = pos * freq;
  assign ph      = ph_full[POSITION_BITS-1:0];

  generate
    if (POSITION_BITS >= NEED) begin : g_narrow
      assign p = ph[POSITION_BITS-1 -: NEED];
    end else begin : g_widen
      assign p = NEED'(ph) << (NEED - POSITION_BITS);
    end
  endgenerate

  assign q   = p[NEED-1 -: 2];
  assign idx = p[COS_INDEX_BITS-1:0];

  always_comb begin
    if (q[0]) begin
      addr_nxt = (COS_INDEX_BITS+1)'(N) - {1'b0, idx};
    end else begin
      addr_nxt = {1'b0, idx};
    end
  end

  always_comb begin
    if (neg3_r) begin
      v = $signed({3'b0, base, 15'b0}) + $signed({2'b0, prod_r});
    end else begin
      v = $signed({3'b0, base, 15'b0}) - $signed({2'b0, prod_r});
    end
    if (v[25]) begin
      chan_nxt = 8'd0;
    end else if (|v[24:23]) begin
      chan_nxt = 8'd255;
    end else begin
      chan_nxt = v[22:15];
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    neg1_r <= q[0] ^ q[1];
    mag_r  <= COS_ROM[addr_r];
    neg2_r <= neg1_r;
    prod_r <= amp * mag_r;
    neg3_r <= neg2_r;
    chan_r <= chan_nxt;
  end

  assign chan = chan_r;

endmodule

>>> design/gpc_poly.sv
module gpc_poly #(
  parameter int POSITION_BITS = gpc_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [47:0]              coeffs,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue
);

  logic [23:0] t1_r, t2a_r, t3a_r;
  logic [24:0] u1_r, u2a_r, u3a_r;
  logic [23:0] sq_t_r, sq_t3_r;
  logic [24:0] sq_u_r, sq_u3_r;
  logic [23:0] cu_t_r;
  logic [24:0] cu_u_r;
  logic [24:0] p_r [3];
  logic [40:0] m_r [3];
  logic [7:0]  c_r [3];

  logic [47:0] t_sq;
  logic [49:0] u_sq;
  logic [47:0] t_cu;
  logic [49:0] u_cu;
  logic [48:0] pr_full, pg_full, pb_full;
  logic [15:0] coeff [3];
  logic [48:0] w [3];
  logic [7:0]  c_nxt [3];

  assign t_sq    = t1_r * t1_r;
  assign u_sq    = u1_r * u1_r;
  assign t_cu    = sq_t_r * t2a_r;
  assign u_cu    = sq_u_r * u2a_r;
  assign pr_full = u3a_r * cu_t_r;
  assign pg_full = sq_u3_r * sq_t3_r;
  assign pb_full = cu_u_r * t3a_r;

  assign coeff[0] = coeffs[15:0];
  assign coeff[1] = coeffs[31:16];
  assign coeff[2] = coeffs[47:32];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w[k] = {m_r[k], 8'b0} - {8'b0, m_r[k]};
      if (|w[k][48:40]) c_nxt[k] = 8'd255;
      else              c_nxt[k] = w[k][39:32];
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= 24'(pos) << (24 - POSITION_BITS);
    u1_r    <= 25'(1 << 24) - {1'b0, 24'(pos) << (24 - POSITION_BITS)};
    sq_t_r  <= t_sq[47:24];
    sq_u_r  <= u_sq[48:24];
    t2a_r   <= t1_r;
    u2a_r   <= u1_r;
    cu_t_r  <= t_cu[47:24];
    cu_u_r  <= u_cu[48:24];
    sq_t3_r <= sq_t_r;
    sq_u3_r <= sq_u_r;
    t3a_r   <= t2a_r;
    u3a_r   <= u2a_r;
    p_r[0]  <= pr_full[48:24];
    p_r[1]  <= pg_full[48:24];
    p_r[2]  <= pb_full[48:24];
    for (int k = 0; k < 3; k++) begin
      m_r[k] <= coeff[k] * p_r[k];
      c_r[k] <= c_nxt[k];
    end
  end

  assign red   = c_r[0];
  assign green = c_r[1];
  assign blue  = c_r[2];

endmodule

>>> design/gradient_palette_color_top.sv
// channel  ports                                   handshake
// in       start, busy, in_position                 taken when start & !busy
// out      out_valid, out_red/green/blue            one-cycle strobe, no hold-off
// cfg      cfg_we, cfg_index, cfg_data              written when cfg_we
//
// One word per cycle; each word taken passes seven register stages on its way
// to the out ports.
// Depth set by the polynomial path: three chained 24-bit products, coefficient
// product and x255 scale, then channel mapping. busy is never raised.
// Synchronous reset clears the valid pipe and restores the register defaults.
module gradient_palette_color_top #(
  parameter int POSITION_BITS  = gpc_pkg::POSITION_BITS_DEF,
  parameter int COS_INDEX_BITS = gpc_pkg::COS_INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [POSITION_BITS-1:0]        in_position,
  output logic                            out_valid,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  input  logic                            cfg_we,
  input  logic [gpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic        mode_r;
  logic [7:0]  base_r, amp_r;
  logic [3:0]  freq_r [3];
  logic [47:0] coeffs_r;
  logic [5:0]  map_r;

  logic [gpc_pkg::LATENCY-2:0] vld_r;
  logic [7:0] cos_c [3];
  logic [7:0] cos_d1_r [3];
  logic [7:0] cos_d2_r [3];
  logic [7:0] poly_c [3];
  logic [7:0] src [3];
  logic [7:0] mapped [3];
  logic [7:0] out_r [3];
  logic       out_valid_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= gpc_pkg::MODE_COSINE;
      base_r    <= gpc_pkg::COS_BASE_RST;
      amp_r     <= gpc_pkg::COS_AMPLITUDE_RST;
      freq_r[0] <= gpc_pkg::FREQ_RED_RST;
      freq_r[1] <= gpc_pkg::FREQ_GREEN_RST;
      freq_r[2] <= gpc_pkg::FREQ_BLUE_RST;
      coeffs_r  <= gpc_pkg::POLY_COEFFS_RST;
      map_r     <= gpc_pkg::CHANNEL_MAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gpc_pkg::CFG_GRADIENT_MODE: mode_r    <= cfg_data[0];
        gpc_pkg::CFG_COS_BASE:      base_r    <= cfg_data[7:0];
        gpc_pkg::CFG_COS_AMPLITUDE: amp_r     <= cfg_data[7:0];
        gpc_pkg::CFG_FREQ_RED:      freq_r[0] <= cfg_data[3:0];
        gpc_pkg::CFG_FREQ_GREEN:    freq_r[1] <= cfg_data[3:0];
        gpc_pkg::CFG_FREQ_BLUE:     freq_r[2] <= cfg_data[3:0];
        gpc_pkg::CFG_POLY_COEFFS:   coeffs_r  <= cfg_data[47:0];
        gpc_pkg::CFG_CHANNEL_MAP:   map_r     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  generate
    for (genvar k = 0; k < 3; k++) begin : g_lane
      gpc_cos_lane #(
        .POSITION_BITS  (POSITION_BITS),
        .COS_INDEX_BITS (COS_INDEX_BITS)
      ) u_lane (
        .clk  (clk),
        .freq (freq_r[k]),
        .pos  (in_position),
        .base (base_r),
        .amp  (amp_r),
        .chan (cos_c[k])
      );
    end
  endgenerate

  gpc_poly #(
    .POSITION_BITS (POSITION_BITS)
  ) u_poly (
    .clk    (clk),
    .pos    (in_position),
    .coeffs (coeffs_r),
    .red    (poly_c[0]),
    .green  (poly_c[1]),
    .blue   (poly_c[2])
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      src[k] = (mode_r == gpc_pkg::MODE_COSINE) ? cos_d2_r[k] : poly_c[k];
    end
    for (int k = 0; k < 3; k++) begin
      case (map_r[2*k +: 2])
        gpc_pkg::MAP_RED:   mapped[k] = src[0];
        gpc_pkg::MAP_GREEN: mapped[k] = src[1];
        gpc_pkg::MAP_BLUE:  mapped[k] = src[2];
        default:            mapped[k] = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[gpc_pkg::LATENCY-3:0], start};
      out_valid_r <= vld_r[gpc_pkg::LATENCY-2];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      cos_d1_r[k] <= cos_c[k];
      cos_d2_r[k] <= cos_d1_r[k];
      out_r[k]    <= mapped[k];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];

endmodule
